/* rtl/signed_int_to_padded_decimal_ascii_defines.svh */
// Assertion helpers shared by the RTL files.
// SIPDA_ASSERT checks a property; SIPDA_NEVER checks that a condition never holds.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef SIGNED_INT_TO_PADDED_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_PADDED_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTH
`define SIPDA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sipda assertion failed");
`define SIPDA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sipda forbidden condition");
`else
`define SIPDA_ASSERT(lbl, prop)
`define SIPDA_NEVER(lbl, cond)
`endif
`endif

/* rtl/sipda_pkg.sv */
package sipda_pkg;

	localparam int VALUE_BITS = 16;
	localparam int WIDTH_BITS = 7;
	localparam int CHAR_BITS  = 6;

	localparam logic [WIDTH_BITS-1:0] MAX_RUN = 7'd64;

	localparam logic [CHAR_BITS-1:0] CH_SPACE = 6'd32;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 6'd45;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 6'd48;

	// decimal digits in the largest magnitude, 2^(bits-1)
	function automatic int dec_digits(input int bits);
		longint v;
		int     n;
		v = longint'(1) << (bits - 1);
		n = 0;
		for (int i = 0; i < 20; i++) begin
			if (v != 0) begin
				n = n + 1;
				v = v / 10;
			end
		end
		return n;
	endfunction

	localparam int NDIG   = dec_digits(VALUE_BITS);
	localparam int NDIG_W = $clog2(NDIG + 1);
	localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [WIDTH_BITS-1:0]        field_width;
	} val_req_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] text_char;
		logic                 last_char;
	} chr_req_t;

	typedef struct packed {
		logic              done;
		logic [NDIG_W-1:0] ndig;
	} bcd_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_NORM,
		B_HOLD
	} bcd_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_CONV,
		T_PAD,
		T_SIGN,
		T_DIGIT
	} fmt_state_t;

endpackage

/* rtl/signed_int_to_padded_decimal_ascii.sv */
// Signed integer to right-justified decimal ASCII text.
// Request channel val_*: one signed value and a field width per request,
// taken at a clock edge with val_valid high and val_stall low. val_stall
// stays high from acceptance until the last character has been handed to
// the output register, so one value is formatted at a time.
// Character channel chr_*: one ASCII character per request, leading spaces,
// then a minus sign for negative values, then the digits, last_char marking
// the final one. The run is max(field width, text length) characters, with
// widths above 64 treated as 64.
// Steps: the value is converted one bit a cycle, then leading zero digits are
// dropped one a cycle (at most NDIG - 1 of them); the first character is
// registered once the converter holds its result in B_HOLD and the control
// has left T_CONV. Characters then leave at one per cycle while chr_stall is low.
// A stalled character holds in the output register; formatting pauses
// until it is taken. A new value is accepted while the last character waits.
// Reset clears the control state and empties the output register.
`include "signed_int_to_padded_decimal_ascii_defines.svh"

module signed_int_to_padded_decimal_ascii import sipda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     val_valid,
	output logic     val_stall,
	input  val_req_t val_req,
	output logic     chr_valid,
	input  logic     chr_stall,
	output chr_req_t chr_req
);

	fmt_state_t            state_q, state_d;
	logic                  neg_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [WIDTH_BITS-1:0] pad_q;
	logic [NDIG_W-1:0]     left_q;
	logic                  chr_valid_q;
	chr_req_t              chr_req_q;

	logic                  accept;
	logic                  free;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [WIDTH_BITS-1:0] width_sat;
	logic [WIDTH_BITS-1:0] text_len;
	logic [WIDTH_BITS-1:0] pad_calc;
	bcd_stat_t             stat;
	logic [3:0]            digit;
	logic                  emit;
	logic                  pop;
	chr_req_t              emit_req;

	// Accept only while idle; the output register may still hold a character.
	assign val_stall = (state_q != T_IDLE);
	assign accept    = val_valid && !val_stall;
	assign free      = !chr_valid_q || !chr_stall;

	// Magnitude in VALUE_BITS unsigned bits covers the most negative value too.
	assign raw       = val_req.value;
	assign mag       = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign width_sat = (val_req.field_width > MAX_RUN) ? MAX_RUN : val_req.field_width;

	assign text_len = WIDTH_BITS'(stat.ndig) + WIDTH_BITS'(neg_q);
	assign pad_calc = (width_q > text_len) ? (width_q - text_len) : '0;

	sipda_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.pop    (pop),
		.stat   (stat),
		.digit  (digit)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (accept) state_d = T_CONV;
			end
			T_CONV: begin
				if (stat.done) begin
					if (pad_calc != '0) state_d = T_PAD;
					else if (neg_q)     state_d = T_SIGN;
					else                state_d = T_DIGIT;
				end
			end
			T_PAD: begin
				if (free && pad_q == WIDTH_BITS'(1)) state_d = neg_q ? T_SIGN : T_DIGIT;
			end
			T_SIGN: begin
				if (free) state_d = T_DIGIT;
			end
			T_DIGIT: begin
				if (free && left_q == NDIG_W'(1)) state_d = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	// Character selection and digit pops
	always_comb begin
		emit               = 1'b0;
		pop                = 1'b0;
		emit_req.text_char = CH_SPACE;
		emit_req.last_char = 1'b0;
		case (state_q)
			T_PAD: begin
				emit = free;
			end
			T_SIGN: begin
				emit               = free;
				emit_req.text_char = CH_MINUS;
			end
			T_DIGIT: begin
				emit               = free;
				pop                = free;
				emit_req.text_char = CH_ZERO + CHAR_BITS'(digit);
				emit_req.last_char = (left_q == NDIG_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			chr_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			chr_valid_q <= emit || (chr_valid_q && chr_stall);
		end
	end

	// Payload: sign, width, remaining counts and the output character
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= raw[VALUE_BITS-1];
			width_q <= width_sat;
		end
		if (state_q == T_CONV && stat.done) begin
			pad_q  <= pad_calc;
			left_q <= stat.ndig;
		end
		if (state_q == T_PAD && free) pad_q <= pad_q - 1'b1;
		if (pop) left_q <= left_q - 1'b1;
		if (emit) chr_req_q <= emit_req;
	end

	assign chr_valid = chr_valid_q;
	assign chr_req   = chr_req_q;

	// Digits are only read once the converter has settled.
	`SIPDA_ASSERT(a_digit_after_conv, (state_q == T_DIGIT) |-> stat.done)
	// The digit count never runs out while digits remain to be sent.
	`SIPDA_NEVER(a_left_nonzero, (state_q == T_DIGIT) && (left_q == '0))
	// A settled conversion has at least one digit and no more than the maximum.
	`SIPDA_ASSERT(a_ndig_range,
		stat.done |-> (stat.ndig != '0) && (stat.ndig <= NDIG_W'(NDIG)))
	// The final digit closes the run and frees the request channel.
	`SIPDA_ASSERT(a_last_frees, (emit && emit_req.last_char) |=> !val_stall)

endmodule

/* rtl/sipda_bcd.sv */
// Bit-serial binary to BCD (shift and add 3), then strip leading zero digits.
module sipda_bcd import sipda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] mag,
	input  logic                  pop,
	output bcd_stat_t             stat,
	output logic [3:0]            digit
);

	bcd_state_t              state_q, state_d;
	logic [NDIG*4-1:0]       bcd_q;
	logic [NDIG*4-1:0]       adj;
	logic [NDIG*4-1:0]       dabble;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NDIG_W-1:0]       nd_q;
	logic                    shrink;

	assign digit  = bcd_q[NDIG*4-1 -: 4];
	assign shrink = (digit == 4'd0) && (nd_q > NDIG_W'(1));

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
		dabble = {adj[NDIG*4-2:0], mag_q[VALUE_BITS-1]};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE, B_HOLD: begin
				if (start) state_d = B_CONV;
			end
			B_CONV: begin
				if (cnt_q == '0) state_d = B_NORM;
			end
			B_NORM: begin
				if (!shrink) state_d = B_HOLD;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		stat.done = (state_q == B_HOLD);
		stat.ndig = nd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE, B_HOLD: begin
				if (start) begin
					mag_q <= mag;
					bcd_q <= '0;
					cnt_q <= CNT_W'(VALUE_BITS - 1);
				end else if (pop) begin
					bcd_q <= bcd_q << 4;
				end
			end
			B_CONV: begin
				bcd_q <= dabble;
				mag_q <= mag_q << 1;
				cnt_q <= cnt_q - 1'b1;
				nd_q  <= NDIG_W'(NDIG);
			end
			B_NORM: begin
				if (shrink) begin
					bcd_q <= bcd_q << 4;
					nd_q  <= nd_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
